// ===== src/tdp_pkg.sv =====
// Shared types and constants for the trial-division prime test.
package tdp_pkg;

  // Candidate width and the width of its magnitude once the sign is known clear
  localparam int CAND_W  = 32;
  localparam int MAG_W   = CAND_W - 1;
  // Trial divisor reaches at most 46341, so 16 bits hold it
  localparam int TRIAL_W = 16;
  localparam int SQ_W    = 2 * TRIAL_W;
  // One restoring step per magnitude bit
  localparam int DIV_STEPS = MAG_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);
  // Output bus is the one-bit flag padded to a byte
  localparam int OUT_W = 8;

  localparam logic [TRIAL_W-1:0] TRIAL_START = TRIAL_W'(2);
  localparam logic [SQ_W-1:0]    SQ_START    = SQ_W'(4);
  localparam logic [MAG_W-1:0]   SMALLEST_PRIME = MAG_W'(2);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_FINISH
  } state_t;

  // Request from the sequencer to the divider
  typedef struct packed {
    logic               start;
    logic [MAG_W-1:0]   dividend;
    logic [TRIAL_W-1:0] divisor;
  } div_req_t;

  // Status from the divider back to the sequencer
  typedef struct packed {
    logic busy;
    logic done;
    logic rem_zero;
  } div_rsp_t;

endpackage

// ===== src/tdp_div.sv =====
// Iterative restoring remainder unit, one quotient bit per cycle.
module tdp_div (
  input  logic            clk,
  input  logic            rst,
  input  tdp_pkg::div_req_t req,
  output tdp_pkg::div_rsp_t rsp
);
  import tdp_pkg::*;

  logic                 busy;
  logic                 done;
  logic [DIV_CNT_W-1:0] cnt;
  logic [MAG_W-1:0]     dvd;
  logic [TRIAL_W-1:0]   dsr;
  logic [TRIAL_W-1:0]   rem;

  logic [TRIAL_W:0]     rem_sh;
  logic [TRIAL_W:0]     diff;
  logic                 fits;

  // Shift in the next dividend bit and trial-subtract the divisor
  always_comb begin
    rem_sh = {rem, dvd[MAG_W-1]};
    diff   = rem_sh - {1'b0, dsr};
    fits   = rem_sh >= {1'b0, dsr};
  end

  // Control: count DIV_STEPS remainder steps after a start, then pulse done
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start && !busy) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + DIV_CNT_W'(1);
        if (cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: load operands, then advance the partial remainder
  always_ff @(posedge clk) begin
    if (req.start && !busy) begin
      dvd <= req.dividend;
      dsr <= req.divisor;
      rem <= '0;
    end else if (busy) begin
      dvd <= {dvd[MAG_W-2:0], 1'b0};
      rem <= fits ? diff[TRIAL_W-1:0] : rem_sh[TRIAL_W-1:0];
    end
  end

  assign rsp.busy     = busy;
  assign rsp.done     = done;
  assign rsp.rem_zero = (rem == '0);

endmodule

// ===== src/trial_division_prime_test_top.sv =====
// Trial-division prime test: sequencer around a shared remainder unit.
// Candidates below 2 or negative go straight to the result; otherwise each
//   trial divisor takes a bound check, the remainder steps and a decision.
// Throughput: one candidate at a time; s_axis_tready is high only while idle.
// Reset (rst, synchronous, active high) returns to idle and drops any result.
module trial_division_prime_test_top (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [tdp_pkg::CAND_W-1:0]  s_axis_tdata,   // [31:0] candidate
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [tdp_pkg::OUT_W-1:0]   m_axis_tdata    // [0] prime_flag, [7:1] zero
);
  import tdp_pkg::*;

  state_t             state, state_next;
  logic [MAG_W-1:0]   n, n_next;
  logic [TRIAL_W-1:0] trial, trial_next;
  logic [SQ_W-1:0]    sq, sq_next;
  logic               result, result_next;
  logic               out_valid, out_valid_next;
  logic               out_flag, out_flag_next;

  div_req_t div_req;
  div_rsp_t div_rsp;

  tdp_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // State and control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    n        <= n_next;
    trial    <= trial_next;
    sq       <= sq_next;
    result   <= result_next;
    out_flag <= out_flag_next;
  end

  // Sequencer: accept, bound check, remainder, advance divisor and square, finish
  always_comb begin
    state_next     = state;
    n_next         = n;
    trial_next     = trial;
    sq_next        = sq;
    result_next    = result;
    out_valid_next = out_valid;
    out_flag_next  = out_flag;
    s_axis_tready  = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = n;
    div_req.divisor  = trial;

    // Drop the held result once it is taken
    if (out_valid && m_axis_tready) begin
      out_valid_next = 1'b0;
    end

    case (state)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          n_next     = s_axis_tdata[MAG_W-1:0];
          trial_next = TRIAL_START;
          sq_next    = SQ_START;
          if (s_axis_tdata[CAND_W-1] || s_axis_tdata[MAG_W-1:0] < SMALLEST_PRIME) begin
            result_next = 1'b0;
            state_next  = ST_FINISH;
          end else begin
            state_next = ST_CHECK;
          end
        end
      end
      ST_CHECK: begin
        if (sq > SQ_W'(n)) begin
          result_next = 1'b1;
          state_next  = ST_FINISH;
        end else begin
          div_req.start = 1'b1;
          state_next    = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          if (div_rsp.rem_zero) begin
            result_next = 1'b0;
            state_next  = ST_FINISH;
          end else begin
            // (t+1)^2 = t^2 + 2t + 1
            trial_next = trial + TRIAL_W'(1);
            sq_next    = sq + SQ_W'({trial, 1'b1});
            state_next = ST_CHECK;
          end
        end
      end
      ST_FINISH: begin
        // Hold until the output register is free
        if (!out_valid || m_axis_tready) begin
          out_valid_next = 1'b1;
          out_flag_next  = result;
          state_next     = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {{(OUT_W-1){1'b0}}, out_flag};

  // Running square must track the divisor at every bound check
  a_square_tracks: assert property (@(posedge clk) disable iff (rst)
    state == ST_CHECK |-> sq == SQ_W'(trial) * SQ_W'(trial))
    else $error("divisor square out of step with divisor");

  // Divider completes only while the sequencer waits on it
  a_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> state == ST_DIV)
    else $error("remainder completed outside the divide state");

  // A start always finds the divider free and launches it
  a_start_launch: assert property (@(posedge clk) disable iff (rst)
    div_req.start |-> !div_rsp.busy ##1 div_rsp.busy)
    else $error("remainder start lost");

  // Never divide by less than two
  a_trial_floor: assert property (@(posedge clk) disable iff (rst)
    state == ST_DIV |-> trial >= TRIAL_START)
    else $error("trial divisor below two");

endmodule
